FILE: rtl/fli_frame_chunk_decoder_macros.svh
// Assertion macros shared by the decoder checker
`ifndef FLI_FRAME_CHUNK_DECODER_MACROS_SVH
`define FLI_FRAME_CHUNK_DECODER_MACROS_SVH

// Check a same-cycle implication, sampled on clk, quiet in reset
`define FCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle, sampled on clk, quiet in reset
`define FCD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fcd_pkg.sv
// Types and constants of the frame chunk decoder
package fcd_pkg;

  typedef enum logic [2:0] {
    KIND_PIXEL   = 3'd0,
    KIND_FILL    = 3'd1,
    KIND_PALETTE = 3'd2,
    KIND_CLEAR   = 3'd3,
    KIND_DONE    = 3'd4
  } kind_t;

  localparam logic [15:0] CHUNK_PALETTE  = 16'd11;
  localparam logic [15:0] CHUNK_DELTA    = 16'd12;
  localparam logic [15:0] CHUNK_CLEAR    = 16'd13;
  localparam logic [15:0] CHUNK_BYTE_RUN = 16'd15;
  localparam logic [15:0] CHUNK_COPY     = 16'd16;

  localparam logic [9:0]  PALETTE_BYTES = 10'd768;
  localparam logic [9:0]  PALETTE_MAX   = 10'd1023;
  localparam logic [15:0] FRAME_HDR_LEN = 16'd16;
  localparam logic [15:0] CHUNK_HDR_LEN = 16'd6;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  value;
    logic [7:0]  run_length;
    logic        palette_changed;
    logic        last;
  } res_t;

  // Results raised by one accepted byte: none, one or two
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

FILE: rtl/fcd_in_if.sv
// Byte request channel of the decoder
interface fcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source(output valid, output data_byte, output frame_start, input ready);
  modport sink(input valid, input data_byte, input frame_start, output ready);
endinterface

FILE: rtl/fcd_out_if.sv
// Result request channel of the decoder
interface fcd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] address;
  logic [7:0]  value;
  logic [7:0]  run_length;
  logic        palette_changed;
  logic        last;

  modport source(output valid, output kind, output address, output value,
                 output run_length, output palette_changed, output last, input ready);
  modport sink(input valid, input kind, input address, input value,
               input run_length, input palette_changed, input last, output ready);
endinterface

FILE: rtl/fcd_core.sv
// Parser state and per-byte decode logic
module fcd_core #(
  parameter int LINE_WIDTH   = 320,
  parameter int LINE_COUNT   = 200,
  parameter int FRAME_PIXELS = 64000
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    data_byte,
  input  logic          frame_start,
  output fcd_pkg::push_t push
);

  localparam int LW_W = $clog2(LINE_WIDTH + 1);
  localparam logic [16:0] FP17 = 17'(FRAME_PIXELS);

  typedef enum logic [4:0] {
    PH_IDLE, PH_FHDR, PH_CHDR, PH_SKIP,
    PH_COL_CNT_LO, PH_COL_CNT_HI, PH_COL_SKIP, PH_COL_LEN, PH_COL_DATA,
    PH_LC_START_LO, PH_LC_START_HI, PH_LC_LINES_LO, PH_LC_LINES_HI,
    PH_LC_PKTS, PH_LC_SKIP, PH_LC_SIZE, PH_LC_COPY, PH_LC_FILL,
    PH_BR_PKTS, PH_BR_SIZE, PH_BR_COPY, PH_BR_FILL,
    PH_CP_DATA
  } ph_t;

  typedef struct packed {
    ph_t         phase;
    logic [3:0]  idx;
    logic [7:0]  wlb;
    logic [15:0] fbl;
    logic [15:0] chunks;
    logic [15:0] cbl;
    logic [15:0] ckind;
    logic [15:0] lines;
    logic [15:0] packets;
    logic [9:0]  run;
    logic [15:0] lb;
    logic [15:0] wp;
    logic [9:0]  pp;
    logic        ps;
  } st_t;

  st_t s_r, s_nxt;
  fcd_pkg::push_t p;
  ph_t ph;
  logic [16:0] sum17;
  logic [16:0] flen;
  logic [10:0] pp11;
  logic [15+LW_W:0] prod;

  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  function automatic fcd_pkg::res_t mk(input fcd_pkg::kind_t k, input logic [15:0] a,
                                       input logic [7:0] v, input logic [7:0] len,
                                       input logic pc);
    fcd_pkg::res_t r;
    r.kind = k; r.address = a; r.value = v; r.run_length = len;
    r.palette_changed = pc; r.last = 1'b0;
    return r;
  endfunction

  function automatic fcd_pkg::push_t add(input fcd_pkg::push_t q, input fcd_pkg::res_t r);
    fcd_pkg::push_t o;
    o = q;
    if (q.n == 2'd0) begin
      o.r0 = r; o.n = 2'd1;
    end else if (q.n == 2'd1) begin
      o.r1 = r; o.n = 2'd2;
    end
    return o;
  endfunction

  function automatic st_t next_line(input st_t si, input ph_t pk);
    st_t so;
    so = si;
    so.lines = si.lines - 16'd1;
    so.lb = sat16({1'b0, si.lb} + 17'(LINE_WIDTH));
    so.phase = (so.lines == 16'd0) ? PH_SKIP : pk;
    return so;
  endfunction

  function automatic st_t packet_done(input st_t si, input ph_t nx, input ph_t pk);
    st_t so;
    so = si;
    so.packets = si.packets - 16'd1;
    if (so.packets == 16'd0) so = next_line(so, pk);
    else so.phase = nx;
    return so;
  endfunction

  always_comb begin
    s_nxt = s_r;
    p = '0;
    ph = s_r.phase;
    sum17 = '0;
    flen = '0;
    pp11 = '0;
    prod = '0;
    if (acc) begin
      if (frame_start) begin
        s_nxt.phase = PH_FHDR;
        s_nxt.wlb = data_byte;
        s_nxt.idx = 4'd1;
        s_nxt.ps = 1'b0;
        s_nxt.fbl = '0;
        s_nxt.chunks = '0;
      end else if (s_nxt.phase == PH_FHDR) begin
        if (s_nxt.idx == 4'd1) s_nxt.fbl = {data_byte, s_nxt.wlb};
        else if (s_nxt.idx == 4'd6) s_nxt.wlb = data_byte;
        else if (s_nxt.idx == 4'd7) s_nxt.chunks = {data_byte, s_nxt.wlb};
        if (s_nxt.idx == 4'd15) begin
          s_nxt.fbl = (s_nxt.fbl > fcd_pkg::FRAME_HDR_LEN) ?
                      s_nxt.fbl - fcd_pkg::FRAME_HDR_LEN : 16'd0;
          if (s_nxt.chunks == 16'd0 || s_nxt.fbl == 16'd0) begin
            p = add(p, mk(fcd_pkg::KIND_DONE, 16'd0, 8'd0, 8'd1, s_nxt.ps));
            s_nxt.phase = PH_IDLE;
          end else begin
            s_nxt.phase = PH_CHDR;
            s_nxt.idx = 4'd0;
          end
        end else begin
          s_nxt.idx = s_nxt.idx + 4'd1;
        end
      end else if (s_nxt.phase != PH_IDLE) begin
        s_nxt.fbl = s_nxt.fbl - 16'd1;
        if (s_nxt.phase == PH_CHDR) begin
          if (s_nxt.idx == 4'd0) s_nxt.wlb = data_byte;
          else if (s_nxt.idx == 4'd1) s_nxt.cbl = {data_byte, s_nxt.wlb};
          else if (s_nxt.idx == 4'd4) s_nxt.wlb = data_byte;
          if (s_nxt.idx >= 4'd5) begin
            s_nxt.ckind = {data_byte, s_nxt.wlb};
            s_nxt.cbl = (s_nxt.cbl > fcd_pkg::CHUNK_HDR_LEN) ?
                        s_nxt.cbl - fcd_pkg::CHUNK_HDR_LEN : 16'd0;
            if (s_nxt.ckind == fcd_pkg::CHUNK_PALETTE) begin
              s_nxt.ps = 1'b1;
              s_nxt.pp = '0;
              s_nxt.phase = PH_COL_CNT_LO;
            end else if (s_nxt.ckind == fcd_pkg::CHUNK_DELTA) begin
              s_nxt.phase = PH_LC_START_LO;
            end else if (s_nxt.ckind == fcd_pkg::CHUNK_CLEAR) begin
              p = add(p, mk(fcd_pkg::KIND_CLEAR, 16'd0, 8'd0, 8'd1, 1'b0));
              s_nxt.phase = PH_SKIP;
            end else if (s_nxt.ckind == fcd_pkg::CHUNK_BYTE_RUN) begin
              s_nxt.lines = 16'(LINE_COUNT);
              s_nxt.lb = '0;
              s_nxt.phase = PH_BR_PKTS;
            end else if (s_nxt.ckind == fcd_pkg::CHUNK_COPY) begin
              s_nxt.wp = '0;
              s_nxt.phase = PH_CP_DATA;
            end else begin
              s_nxt.phase = PH_SKIP;
            end
          end else begin
            s_nxt.idx = s_nxt.idx + 4'd1;
          end
        end else begin
          s_nxt.cbl = s_nxt.cbl - 16'd1;
          unique case (ph)
            PH_COL_CNT_LO: begin
              s_nxt.wlb = data_byte;
              s_nxt.phase = PH_COL_CNT_HI;
            end
            PH_COL_CNT_HI: begin
              s_nxt.packets = {data_byte, s_nxt.wlb};
              s_nxt.phase = (s_nxt.packets == 16'd0) ? PH_SKIP : PH_COL_SKIP;
            end
            PH_COL_SKIP: begin
              pp11 = {1'b0, s_nxt.pp} + {2'd0, data_byte, 1'b0} + {3'd0, data_byte};
              s_nxt.pp = (pp11 > 11'd1023) ? fcd_pkg::PALETTE_MAX : pp11[9:0];
              s_nxt.phase = PH_COL_LEN;
            end
            PH_COL_LEN: begin
              s_nxt.run = (data_byte != 8'd0) ?
                          ({1'b0, data_byte, 1'b0} + {2'd0, data_byte}) :
                          fcd_pkg::PALETTE_BYTES;
              s_nxt.phase = PH_COL_DATA;
            end
            PH_COL_DATA: begin
              if (s_nxt.pp < fcd_pkg::PALETTE_BYTES)
                p = add(p, mk(fcd_pkg::KIND_PALETTE, {6'd0, s_nxt.pp}, data_byte, 8'd1, 1'b0));
              if (s_nxt.pp < fcd_pkg::PALETTE_MAX) s_nxt.pp = s_nxt.pp + 10'd1;
              s_nxt.run = s_nxt.run - 10'd1;
              if (s_nxt.run == 10'd0) begin
                s_nxt.packets = s_nxt.packets - 16'd1;
                s_nxt.phase = (s_nxt.packets == 16'd0) ? PH_SKIP : PH_COL_SKIP;
              end
            end
            PH_LC_START_LO, PH_LC_LINES_LO: begin
              s_nxt.wlb = data_byte;
              s_nxt.phase = (ph == PH_LC_START_LO) ? PH_LC_START_HI : PH_LC_LINES_HI;
            end
            PH_LC_START_HI: begin
              prod = {data_byte, s_nxt.wlb} * LW_W'(LINE_WIDTH);
              s_nxt.lb = (prod > (16+LW_W)'(16'hFFFF)) ? 16'hFFFF : prod[15:0];
              s_nxt.phase = PH_LC_LINES_LO;
            end
            PH_LC_LINES_HI: begin
              s_nxt.lines = {data_byte, s_nxt.wlb};
              s_nxt.phase = (s_nxt.lines == 16'd0) ? PH_SKIP : PH_LC_PKTS;
            end
            PH_LC_PKTS, PH_BR_PKTS: begin
              s_nxt.packets = {8'd0, data_byte};
              s_nxt.wp = s_nxt.lb;
              if (data_byte == 8'd0) s_nxt = next_line(s_nxt, ph);
              else s_nxt.phase = (ph == PH_LC_PKTS) ? PH_LC_SKIP : PH_BR_SIZE;
            end
            PH_LC_SKIP: begin
              s_nxt.wp = sat16({1'b0, s_nxt.wp} + {9'd0, data_byte});
              s_nxt.phase = PH_LC_SIZE;
            end
            PH_LC_SIZE: begin
              if (data_byte[7]) begin
                s_nxt.run = 10'd256 - {2'd0, data_byte};
                s_nxt.phase = PH_LC_FILL;
              end else if (data_byte == 8'd0) begin
                s_nxt = packet_done(s_nxt, PH_LC_SKIP, PH_LC_PKTS);
              end else begin
                s_nxt.run = {2'd0, data_byte};
                s_nxt.phase = PH_LC_COPY;
              end
            end
            PH_BR_SIZE: begin
              if (data_byte[7]) begin
                s_nxt.run = 10'd256 - {2'd0, data_byte};
                s_nxt.phase = PH_BR_COPY;
              end else begin
                s_nxt.run = {2'd0, data_byte};
                s_nxt.phase = PH_BR_FILL;
              end
            end
            PH_LC_COPY, PH_BR_COPY, PH_CP_DATA: begin
              if ({1'b0, s_nxt.wp} < FP17)
                p = add(p, mk(fcd_pkg::KIND_PIXEL, s_nxt.wp, data_byte, 8'd1, 1'b0));
              s_nxt.wp = sat16({1'b0, s_nxt.wp} + 17'd1);
              if (ph == PH_CP_DATA) begin
                if ({1'b0, s_nxt.wp} >= FP17) s_nxt.phase = PH_SKIP;
              end else begin
                s_nxt.run = s_nxt.run - 10'd1;
                if (s_nxt.run == 10'd0) begin
                  if (ph == PH_LC_COPY) s_nxt = packet_done(s_nxt, PH_LC_SKIP, PH_LC_PKTS);
                  else s_nxt = packet_done(s_nxt, PH_BR_SIZE, PH_BR_PKTS);
                end
              end
            end
            PH_LC_FILL, PH_BR_FILL: begin
              sum17 = {1'b0, s_nxt.wp} + {7'd0, s_nxt.run};
              if ({1'b0, s_nxt.wp} < FP17 && s_nxt.run != 10'd0) begin
                flen = (sum17 > FP17) ? FP17 - {1'b0, s_nxt.wp} : {7'd0, s_nxt.run};
                p = add(p, mk(fcd_pkg::KIND_FILL, s_nxt.wp, data_byte, flen[7:0], 1'b0));
              end
              s_nxt.wp = sat16(sum17);
              if (ph == PH_LC_FILL) s_nxt = packet_done(s_nxt, PH_LC_SKIP, PH_LC_PKTS);
              else s_nxt = packet_done(s_nxt, PH_BR_SIZE, PH_BR_PKTS);
            end
            default: begin
            end
          endcase
          if (s_nxt.cbl == 16'd0) begin
            // chunk over: move to the next header or close the frame
            s_nxt.chunks = s_nxt.chunks - 16'd1;
            if (s_nxt.chunks == 16'd0) begin
              p = add(p, mk(fcd_pkg::KIND_DONE, 16'd0, 8'd0, 8'd1, s_nxt.ps));
              s_nxt.phase = PH_IDLE;
            end else begin
              s_nxt.phase = PH_CHDR;
              s_nxt.idx = 4'd0;
            end
          end
        end
        if (ph == PH_CHDR && s_nxt.phase != PH_CHDR && s_nxt.cbl == 16'd0) begin
          s_nxt.chunks = s_nxt.chunks - 16'd1;
          if (s_nxt.chunks == 16'd0) begin
            p = add(p, mk(fcd_pkg::KIND_DONE, 16'd0, 8'd0, 8'd1, s_nxt.ps));
            s_nxt.phase = PH_IDLE;
          end else begin
            s_nxt.phase = PH_CHDR;
            s_nxt.idx = 4'd0;
          end
        end
        if (s_nxt.phase != PH_IDLE && s_nxt.fbl == 16'd0) begin
          p = add(p, mk(fcd_pkg::KIND_DONE, 16'd0, 8'd0, 8'd1, s_nxt.ps));
          s_nxt.phase = PH_IDLE;
        end
      end
    end
    if (p.n == 2'd1) p.r0.last = 1'b1;
    if (p.n == 2'd2) p.r1.last = 1'b1;
  end

  assign push = p;

  // PH_IDLE encodes as zero, so clearing the whole state resets the parser
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else begin
      s_r <= s_nxt;
    end
  end

endmodule

FILE: rtl/fcd_res_fifo.sv
// Four-entry result queue, up to two writes and one read per cycle
module fcd_res_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  fcd_pkg::push_t push,
  input  logic           pop,
  output logic           room,
  output logic           not_empty,
  output fcd_pkg::res_t  head
);

  localparam int PW = $clog2(fcd_pkg::FIFO_DEPTH);

  fcd_pkg::res_t mem_r [fcd_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   count_r;
  logic [PW-1:0] wr_p1;

  assign wr_p1     = wr_r + PW'(1);
  assign room      = count_r <= (PW+1)'(fcd_pkg::FIFO_DEPTH - 2);
  assign not_empty = count_r != '0;
  assign head      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_r] <= push.r0;
    if (push.n == 2'd2) mem_r[wr_p1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_r + PW'(push.n);
      rd_r    <= rd_r + PW'(pop);
      count_r <= count_r + (PW+1)'(push.n) - (PW+1)'(pop);
    end
  end

endmodule

FILE: rtl/fli_frame_chunk_decoder.sv
// Top level of the FLI frame chunk decoder
//
// Use: feed FLI frame bytes on in_ch, one request per byte, with frame_start
// high on byte 0 of each 16-byte frame header. Results leave on out_ch as
// pixel writes, fill runs, palette byte writes, clear commands and a frame
// done request carrying the palette-changed flag. last marks the final result
// raised by one input byte; a byte raises zero, one or two results.
// Results are written into the result queue as their byte is taken and leave from its head.
// Throughput: one byte per cycle while the receiver keeps up; the decode
// logic between the parser state register and the four-entry result queue
// settles a whole byte combinationally. A byte raising two results needs two
// output transfers, so the queue may fill and in_ch.ready drops while
// fewer than two queue slots are free.
// Reset (synchronous, rst_n low): parser returns to waiting for a frame
// header and the result queue empties; in_ch.ready is high once it has emptied.
// Stall: when out_ch.ready is low the head result holds and input bytes are
// still taken until the queue cannot absorb two more results.
module fli_frame_chunk_decoder #(
  parameter int LINE_WIDTH   = 320,
  parameter int LINE_COUNT   = 200,
  parameter int FRAME_PIXELS = 64000
) (
  input  logic      clk,
  input  logic      rst_n,
  fcd_in_if.sink    in_ch,
  fcd_out_if.source out_ch
);

  fcd_pkg::push_t push;
  fcd_pkg::res_t  head;
  logic           room;
  logic           not_empty;
  logic           acc;

  // take a byte whenever the queue can absorb its worst case of two results
  assign in_ch.ready = room;
  assign acc = in_ch.valid && room;

  fcd_core #(
    .LINE_WIDTH  (LINE_WIDTH),
    .LINE_COUNT  (LINE_COUNT),
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_ch.data_byte),
    .frame_start(in_ch.frame_start),
    .push       (push)
  );

  fcd_res_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (not_empty && out_ch.ready),
    .room     (room),
    .not_empty(not_empty),
    .head     (head)
  );

  // drive the result request from the queue head
  assign out_ch.valid           = not_empty;
  assign out_ch.kind            = head.kind;
  assign out_ch.address         = head.address;
  assign out_ch.value           = head.value;
  assign out_ch.run_length      = head.run_length;
  assign out_ch.palette_changed = head.palette_changed;
  assign out_ch.last            = head.last;

endmodule

FILE: rtl/fcd_checker.sv
// Port-level checker for the frame chunk decoder and its bind
`include "fli_frame_chunk_decoder_macros.svh"

module fcd_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [15:0] address,
  input logic        palette_changed,
  input logic        last
);

  logic is_done;

  assign is_done = kind == fcd_pkg::KIND_DONE;

  `FCD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `FCD_ASSERT_IMP(a_kind_range, out_valid, kind <= fcd_pkg::KIND_DONE, "result kind out of range")
  `FCD_ASSERT_IMP(a_pc_only_done, out_valid && !is_done, !palette_changed, "stray palette flag")
  `FCD_ASSERT_IMP(a_done_shape, out_valid && is_done, address == 16'd0 && last, "frame done malformed")
  `FCD_ASSERT_IMP(a_ready_empty, !out_valid, in_ready, "input held off with an empty queue")

endmodule

bind fli_frame_chunk_decoder fcd_port_checker u_fcd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .kind           (out_ch.kind),
  .address        (out_ch.address),
  .palette_changed(out_ch.palette_changed),
  .last           (out_ch.last)
);

FILE: tb/fcd_checker.sv
// Checker of the frame chunk decoder: predicts results from accepted bytes and compares
module fcd_checker #(
  parameter int LINE_WIDTH   = 320,
  parameter int LINE_COUNT   = 200,
  parameter int FRAME_PIXELS = 64000
) (
  input  logic clk,
  input  logic rst_n,
  fcd_in_if    in_ch,
  fcd_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    PH_IDLE, PH_FHDR, PH_CHDR, PH_SKIP,
    PH_COL_CNT_LO, PH_COL_CNT_HI, PH_COL_SKIP, PH_COL_LEN, PH_COL_DATA,
    PH_LC_START_LO, PH_LC_START_HI, PH_LC_LINES_LO, PH_LC_LINES_HI,
    PH_LC_PKTS, PH_LC_SKIP, PH_LC_SIZE, PH_LC_COPY, PH_LC_FILL,
    PH_BR_PKTS, PH_BR_SIZE, PH_BR_COPY, PH_BR_FILL,
    PH_CP_DATA
  } phase_t;

  phase_t phase;
  int hdr_idx, low_byte, frame_left, chunks_left, chunk_left, chunk_code;
  int lines_left, pkts_left, run_left, line_base, wptr, pal_ptr;
  bit pal_seen;

  fcd_pkg::res_t expected_q[$];
  fcd_pkg::res_t step_q[$];

  assign pending = expected_q.size();

  function automatic int sat16(int v);
    return (v > 16'hFFFF) ? 16'hFFFF : v;
  endfunction

  function automatic void emit(fcd_pkg::kind_t k, int a, int v, int len, bit pc);
    fcd_pkg::res_t r;
    if (step_q.size() >= 2) return;
    r.kind = k;
    r.address = a[15:0];
    r.value = v[7:0];
    r.run_length = len[7:0];
    r.palette_changed = pc;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void put_pixel(int b);
    if (wptr < FRAME_PIXELS) emit(fcd_pkg::KIND_PIXEL, wptr, b, 1, 0);
    wptr = sat16(wptr + 1);
  endfunction

  function automatic void put_fill(int b);
    int len;
    len = run_left;
    if (wptr < FRAME_PIXELS && len > 0) begin
      if (wptr + len > FRAME_PIXELS) len = FRAME_PIXELS - wptr;
      emit(fcd_pkg::KIND_FILL, wptr, b, len, 0);
    end
    wptr = sat16(wptr + run_left);
  endfunction

  function automatic void close_frame();
    emit(fcd_pkg::KIND_DONE, 0, 0, 1, pal_seen);
    phase = PH_IDLE;
  endfunction

  function automatic void advance_line(phase_t pk);
    lines_left = (lines_left - 1) & 16'hFFFF;
    line_base = sat16(line_base + LINE_WIDTH);
    phase = (lines_left == 0) ? PH_SKIP : pk;
  endfunction

  function automatic void close_packet(phase_t nxt, phase_t pk);
    pkts_left = (pkts_left - 1) & 16'hFFFF;
    if (pkts_left == 0) advance_line(pk);
    else phase = nxt;
  endfunction

  function automatic void close_chunk();
    chunks_left = (chunks_left - 1) & 16'hFFFF;
    if (chunks_left == 0) close_frame();
    else begin
      phase = PH_CHDR;
      hdr_idx = 0;
    end
  endfunction

  function automatic void open_chunk();
    chunk_left = (chunk_left > 6) ? chunk_left - 6 : 0;
    case (chunk_code)
      fcd_pkg::CHUNK_PALETTE: begin
        pal_seen = 1;
        pal_ptr = 0;
        phase = PH_COL_CNT_LO;
      end
      fcd_pkg::CHUNK_DELTA: phase = PH_LC_START_LO;
      fcd_pkg::CHUNK_CLEAR: begin
        emit(fcd_pkg::KIND_CLEAR, 0, 0, 1, 0);
        phase = PH_SKIP;
      end
      fcd_pkg::CHUNK_BYTE_RUN: begin
        lines_left = LINE_COUNT;
        line_base = 0;
        phase = PH_BR_PKTS;
      end
      fcd_pkg::CHUNK_COPY: begin
        wptr = 0;
        phase = PH_CP_DATA;
      end
      default: phase = PH_SKIP;
    endcase
    if (chunk_left == 0) close_chunk();
  endfunction

  function automatic void decode_payload(int b);
    case (phase)
      PH_COL_CNT_LO: begin low_byte = b; phase = PH_COL_CNT_HI; end
      PH_COL_CNT_HI: begin
        pkts_left = low_byte | (b << 8);
        phase = (pkts_left == 0) ? PH_SKIP : PH_COL_SKIP;
      end
      PH_COL_SKIP: begin
        pal_ptr = pal_ptr + b * 3;
        if (pal_ptr > fcd_pkg::PALETTE_MAX) pal_ptr = fcd_pkg::PALETTE_MAX;
        phase = PH_COL_LEN;
      end
      PH_COL_LEN: begin
        run_left = (b != 0) ? b * 3 : fcd_pkg::PALETTE_BYTES;
        phase = PH_COL_DATA;
      end
      PH_COL_DATA: begin
        if (pal_ptr < fcd_pkg::PALETTE_BYTES) emit(fcd_pkg::KIND_PALETTE, pal_ptr, b, 1, 0);
        if (pal_ptr < fcd_pkg::PALETTE_MAX) pal_ptr++;
        run_left--;
        if (run_left == 0) begin
          pkts_left = (pkts_left - 1) & 16'hFFFF;
          phase = (pkts_left == 0) ? PH_SKIP : PH_COL_SKIP;
        end
      end
      PH_LC_START_LO: begin low_byte = b; phase = PH_LC_START_HI; end
      PH_LC_START_HI: begin
        line_base = sat16((low_byte | (b << 8)) * LINE_WIDTH);
        phase = PH_LC_LINES_LO;
      end
      PH_LC_LINES_LO: begin low_byte = b; phase = PH_LC_LINES_HI; end
      PH_LC_LINES_HI: begin
        lines_left = low_byte | (b << 8);
        phase = (lines_left == 0) ? PH_SKIP : PH_LC_PKTS;
      end
      PH_LC_PKTS, PH_BR_PKTS: begin
        pkts_left = b;
        wptr = line_base;
        if (b == 0) advance_line(phase);
        else phase = (phase == PH_LC_PKTS) ? PH_LC_SKIP : PH_BR_SIZE;
      end
      PH_LC_SKIP: begin wptr = sat16(wptr + b); phase = PH_LC_SIZE; end
      PH_LC_SIZE: begin
        if (b & 8'h80) begin run_left = 256 - b; phase = PH_LC_FILL; end
        else if (b == 0) close_packet(PH_LC_SKIP, PH_LC_PKTS);
        else begin run_left = b; phase = PH_LC_COPY; end
      end
      PH_BR_SIZE: begin
        if (b & 8'h80) begin run_left = 256 - b; phase = PH_BR_COPY; end
        else begin run_left = b; phase = PH_BR_FILL; end
      end
      PH_LC_COPY, PH_BR_COPY: begin
        put_pixel(b);
        run_left--;
        if (run_left == 0) begin
          if (phase == PH_LC_COPY) close_packet(PH_LC_SKIP, PH_LC_PKTS);
          else close_packet(PH_BR_SIZE, PH_BR_PKTS);
        end
      end
      PH_LC_FILL: begin put_fill(b); close_packet(PH_LC_SKIP, PH_LC_PKTS); end
      PH_BR_FILL: begin put_fill(b); close_packet(PH_BR_SIZE, PH_BR_PKTS); end
      PH_CP_DATA: begin
        put_pixel(b);
        if (wptr >= FRAME_PIXELS) phase = PH_SKIP;
      end
      default: ;
    endcase
  endfunction

  // Advance the decoder state by one accepted request and queue its results
  function automatic void predict_byte(int b, bit fs);
    step_q.delete();
    if (fs) begin
      phase = PH_FHDR;
      low_byte = b;
      hdr_idx = 1;
      pal_seen = 0;
      frame_left = 0;
      chunks_left = 0;
    end else if (phase == PH_FHDR) begin
      case (hdr_idx)
        1: frame_left = low_byte | (b << 8);
        6: low_byte = b;
        7: chunks_left = low_byte | (b << 8);
        default: ;
      endcase
      if (hdr_idx >= 15) begin
        frame_left = (frame_left > 16) ? frame_left - 16 : 0;
        if (chunks_left == 0 || frame_left == 0) close_frame();
        else begin
          phase = PH_CHDR;
          hdr_idx = 0;
        end
      end else hdr_idx++;
    end else if (phase != PH_IDLE) begin
      frame_left = (frame_left - 1) & 16'hFFFF;
      if (phase == PH_CHDR) begin
        case (hdr_idx)
          0: low_byte = b;
          1: chunk_left = low_byte | (b << 8);
          4: low_byte = b;
          default: ;
        endcase
        if (hdr_idx >= 5) begin
          chunk_code = low_byte | (b << 8);
          open_chunk();
        end else hdr_idx++;
      end else begin
        chunk_left = (chunk_left - 1) & 16'hFFFF;
        decode_payload(b);
        if (chunk_left == 0) close_chunk();
      end
      if (phase != PH_IDLE && frame_left == 0) close_frame();
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  always @(posedge clk) begin
    fcd_pkg::res_t want;
    if (!rst_n) begin
      phase = PH_IDLE;
      hdr_idx = 0; low_byte = 0; frame_left = 0; chunks_left = 0;
      chunk_left = 0; chunk_code = 0; lines_left = 0; pkts_left = 0;
      run_left = 0; line_base = 0; wptr = 0; pal_ptr = 0; pal_seen = 0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_byte(in_ch.data_byte, in_ch.frame_start);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result kind=%0d addr=%0d", out_ch.kind, out_ch.address);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.kind !== want.kind || out_ch.address !== want.address ||
              out_ch.value !== want.value || out_ch.run_length !== want.run_length ||
              out_ch.palette_changed !== want.palette_changed ||
              out_ch.last !== want.last) begin
            if (fail_count < 10)
              $display("exp k%0d a%0d v%0d n%0d p%0b l%0b, got k%0d a%0d v%0d n%0d p%0b l%0b",
                       want.kind, want.address, want.value, want.run_length,
                       want.palette_changed, want.last, out_ch.kind, out_ch.address,
                       out_ch.value, out_ch.run_length, out_ch.palette_changed, out_ch.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: tb/fli_frame_chunk_decoder_tb.sv
// Top of the decoder testbench: builds byte streams, drives them and gives the verdict
module fli_frame_chunk_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1350;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [7:0] b;
    logic       fs;
  } req_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  bit   calm;           // no idling on either side once set

  req_t byte_q[$];     // request stream, built up front
  logic [7:0] body_q[$];
  logic [7:0] chunk_q[$];

  fcd_in_if  in_ch();
  fcd_out_if out_ch();

  fli_frame_chunk_decoder i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  fcd_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold the frame-start flag only on header byte 0
  function automatic void push_byte(int b, bit fs = 0);
    req_t r;
    r.b = b[7:0];
    r.fs = fs;
    byte_q.push_back(r);
  endfunction

  function automatic void put_word(ref logic [7:0] q[$], input int w);
    q.push_back(w[7:0]);
    q.push_back(w[15:8]);
  endfunction

  // Build one chunk's payload with a plausible structure and random content
  function automatic int build_payload(ref logic [7:0] p[$]);
    int kind_sel, ctype, n, k, lines, pkts;
    kind_sel = $urandom_range(0, 9);
    case (kind_sel)
      0, 1: begin
        ctype = fcd_pkg::CHUNK_PALETTE;
        pkts = $urandom_range(1, 2);
        put_word(p, pkts);
        repeat (pkts) begin
          p.push_back(($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 3)));
          k = $urandom_range(0, 40);
          n = (k == 0) ? 0 : (k == 1) ? 255 : $urandom_range(1, 3);
          p.push_back(8'(n));
          repeat ((n == 0) ? 768 : n * 3) p.push_back(8'($urandom));
        end
      end
      2, 3, 4: begin
        ctype = fcd_pkg::CHUNK_DELTA;
        k = $urandom_range(0, 9);
        put_word(p, (k == 0) ? 16'hFFFF : (k == 1) ? 199 : $urandom_range(0, 205));
        lines = $urandom_range(1, 3);
        put_word(p, lines);
        repeat (lines) begin
          pkts = $urandom_range(0, 2);
          p.push_back(8'(pkts));
          repeat (pkts) begin
            p.push_back(8'($urandom));
            k = $urandom_range(0, 9);
            if (k == 0) p.push_back(8'h00);
            else if (k < 5) begin
              n = $urandom_range(1, 4);
              p.push_back(8'(n));
              repeat (n) p.push_back(8'($urandom));
            end else begin
              n = $urandom_range(1, 128);
              p.push_back(8'(256 - n));
              p.push_back(8'($urandom));
            end
          end
        end
      end
      5: ctype = fcd_pkg::CHUNK_CLEAR;
      6, 7: begin
        ctype = fcd_pkg::CHUNK_BYTE_RUN;
        lines = $urandom_range(1, 3);
        repeat (lines) begin
          pkts = $urandom_range(0, 2);
          p.push_back(8'(pkts));
          repeat (pkts) begin
            if ($urandom_range(0, 1)) begin
              n = $urandom_range(1, 4);
              p.push_back(8'(256 - n));
              repeat (n) p.push_back(8'($urandom));
            end else begin
              p.push_back(8'($urandom_range(0, 127)));
              p.push_back(8'($urandom));
            end
          end
        end
      end
      8: begin
        ctype = fcd_pkg::CHUNK_COPY;
        repeat ($urandom_range(1, 30)) p.push_back(8'($urandom));
      end
      default: begin
        do ctype = $urandom_range(0, 16'hFFFF);
        while (ctype inside {fcd_pkg::CHUNK_PALETTE, fcd_pkg::CHUNK_DELTA,
                             fcd_pkg::CHUNK_CLEAR, fcd_pkg::CHUNK_BYTE_RUN,
                             fcd_pkg::CHUNK_COPY});
        repeat ($urandom_range(0, 8)) p.push_back(8'($urandom));
      end
    endcase
    return ctype;
  endfunction

  // Build a frame: header, then a few chunks whose sizes are mostly honest
  function automatic void build_frame();
    int nchunks, ctype, csize, fsize, k;
    body_q.delete();
    nchunks = $urandom_range(1, 4);
    repeat (nchunks) begin
      chunk_q.delete();
      ctype = build_payload(chunk_q);
      csize = 6 + chunk_q.size();
      k = $urandom_range(0, 19);
      if (k == 0) csize = $urandom_range(0, 5);               // shorter than a header
      else if (k < 3) csize = $urandom_range(6, csize);       // cut the payload off
      else if (k < 5) begin                                    // trailing padding
        repeat ($urandom_range(1, 4)) chunk_q.push_back(8'($urandom));
        csize = 6 + chunk_q.size();
      end
      put_word(body_q, csize);
      put_word(body_q, int'($urandom));
      put_word(body_q, ctype);
      foreach (chunk_q[i]) body_q.push_back(chunk_q[i]);
    end
    fsize = 16 + body_q.size();
    k = $urandom_range(0, 15);
    if (k == 0) fsize = 16 + $urandom_range(0, body_q.size());  // frame runs out early
    else if (k == 1) nchunks = nchunks + 2;                     // chunk count overstated
    push_byte(fsize[7:0], 1);
    push_byte(fsize[15:8]);
    repeat (4) push_byte(int'($urandom));
    push_byte(nchunks[7:0]);
    push_byte(nchunks[15:8]);
    repeat (8) push_byte(int'($urandom));
    foreach (body_q[i]) push_byte(body_q[i]);
  endfunction

  // Drive one request and hold it until taken
  task automatic send_byte(req_t r);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= r.b;
    in_ch.frame_start <= r.fs;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Result side: random stall bursts, none once calm
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm || $urandom_range(0, 4) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int total, half;
    int fsz;
    rst_n = 1'b0;
    calm = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.frame_start = 1'b0;

    // Directed: stray bytes outside a frame, a frame of zero chunks with
    // extreme header bytes, a short frame size, then a restart mid header
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF, 1);
    push_byte(8'hFF);
    repeat (4) push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h00);
    repeat (8) push_byte(8'h00);
    fsz = 5;
    push_byte(fsz, 1);
    push_byte(8'h00);
    repeat (4) push_byte(8'h00);
    push_byte(8'h01);
    repeat (9) push_byte(8'h80);
    push_byte(8'h40, 1);
    push_byte(8'h00);
    push_byte(8'h55);
    while (byte_q.size() < ITEM_TARGET) build_frame();
    total = byte_q.size();
    half = total / 2;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < total; i++) begin
      if (i == half) begin
        // Hold off until the decoder has drained everything owed
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (i == total - total / 7) calm = 1'b1;
      send_byte(byte_q[i]);
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
